/* hw/rtl/quadrature_position_velocity_macros.svh */
// Assertion macros for the quadrature position and velocity sequencer.
`ifndef QUADRATURE_POSITION_VELOCITY_MACROS_SVH
`define QUADRATURE_POSITION_VELOCITY_MACROS_SVH

// same-cycle implication
`define QPV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication
`define QPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/qpv_pkg.sv */
// Types and constants of the quadrature position and velocity block.
package qpv_pkg;

	localparam int TS_W     = 32;
	localparam int VEL_W    = 32;
	localparam int ANGLE_W  = 34;
	localparam int MAG_PAD  = 64;	// padded magnitude for the split multiply
	localparam int PROD_W   = 96;
	localparam int QUO_W    = 33;	// quotient bits kept by the divider
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = 6;

	localparam logic [31:0] TICK_RATE_RST    = 32'd90000000;
	localparam logic [31:0] MIN_INTERVAL_RST = 32'd22500000;
	localparam logic [31:0] MAX_INTERVAL_RST = 32'd45000000;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_BWD  = 2'd2,
		DIR_ERR  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		REG_TICK_RATE    = 2'd0,
		REG_MIN_INTERVAL = 2'd1,
		REG_MAX_INTERVAL = 2'd2,
		REG_REVERSE      = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CHECK,
		ST_DIV,
		ST_FINISH,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic check;
		logic div_step;
		logic finish;
	} arith_ctrl_t;

	typedef struct packed {
		logic early;	// result known at check, no divide needed
	} arith_stat_t;

endpackage

/* hw/rtl/qpv_in_if.sv */
// Input channel: one polled encoder sample word.
interface qpv_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  phase;
	logic [31:0] timestamp;
	logic        acknowledge;

	modport source (output valid, phase, timestamp, acknowledge, input ready);
	modport sink   (input valid, phase, timestamp, acknowledge, output ready);
endinterface

/* hw/rtl/qpv_out_if.sv */
// Output channel: one position and velocity result word.
interface qpv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] step_count;
	logic signed [33:0] angle_tenths;
	logic signed [31:0] velocity_tenths;
	logic [1:0]         direction;
	logic               error_flag;

	modport source (output valid, step_count, angle_tenths, velocity_tenths, direction,
		error_flag, input ready);
	modport sink   (input valid, step_count, angle_tenths, velocity_tenths, direction,
		error_flag, output ready);
endinterface

/* hw/rtl/qpv_arith.sv */
// Shared velocity datapath: one 32x32 multiplier and one 33-bit restoring divide step.
module qpv_arith import qpv_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  arith_ctrl_t            ctrl,
	input  logic [COUNT_WIDTH+2:0] mag_in,
	input  logic                   neg_in,
	input  logic [31:0]            tick_rate,
	input  logic [TS_W-1:0]        gap,
	output arith_stat_t            stat,
	output logic [VEL_W-1:0]       speed
);

	logic [MAG_PAD-1:0] mag_q;
	logic               neg_q;
	logic [31:0]        tr_q;
	logic [TS_W-1:0]    gap_q;
	logic [PROD_W-1:0]  prod_q;
	logic [TS_W-1:0]    rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic               zero_q, sat_q;
	logic [VEL_W-1:0]   speed_q;

	logic [31:0]       mul_a;
	logic [63:0]       mul_p;
	logic              zero_c, sat_c;
	logic [TS_W:0]     trial;
	logic [TS_W:0]     trial_sub;
	logic              trial_ok;
	logic [QUO_W-1:0]  lim;
	logic [QUO_W-1:0]  q_sat;
	logic [QUO_W-1:0]  q_neg;
	logic [VEL_W-1:0]  result;

	assign mul_a = ctrl.mul_hi ? mag_q[63:32] : mag_q[31:0];
	assign mul_p = 64'(mul_a) * 64'(tr_q);

	assign zero_c = (mag_q == '0) || (tr_q == '0);
	// quotient would exceed 33 bits (also covers a zero gap)
	assign sat_c  = prod_q[PROD_W-1:QUO_W] >= 63'(gap_q);
	assign stat.early = zero_c || sat_c;

	assign trial     = {rem_q, quo_q[QUO_W-1]};
	assign trial_ok  = trial >= {1'b0, gap_q};
	assign trial_sub = trial - {1'b0, gap_q};

	assign lim    = neg_q ? 33'h080000000 : 33'h07FFFFFFF;
	assign q_sat  = (sat_q || (quo_q > lim)) ? lim : quo_q;
	assign q_neg  = '0 - q_sat;
	assign result = zero_q ? '0 : (neg_q ? q_neg[VEL_W-1:0] : q_sat[VEL_W-1:0]);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= MAG_PAD'(mag_in);
			neg_q <= neg_in;
			tr_q  <= tick_rate;
			gap_q <= gap;
		end
		if (ctrl.mul_lo)
			prod_q <= PROD_W'(mul_p);
		else if (ctrl.mul_hi)
			prod_q <= prod_q + {mul_p, 32'd0};
		if (ctrl.check) begin
			zero_q <= zero_c;
			sat_q  <= sat_c;
			rem_q  <= prod_q[QUO_W +: TS_W];
			quo_q  <= prod_q[QUO_W-1:0];
		end else if (ctrl.div_step) begin
			rem_q <= trial_ok ? trial_sub[TS_W-1:0] : trial[TS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
		end else if (ctrl.finish) begin
			speed_q <= result;
		end
	end

	assign speed = speed_q;

endmodule

/* hw/rtl/qpv_seq.sv */
// Sequencer for the velocity datapath and the output register.
module qpv_seq import qpv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        upd,
	input  logic        silent,
	input  logic        out_free,
	input  arith_stat_t stat,
	output logic        in_ready,
	output logic        out_load,
	output arith_ctrl_t ctrl
);
	`include "quadrature_position_velocity_macros.svh"

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 in_fire;

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		ctrl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !silent) begin
					if (upd) begin
						ctrl.load = 1'b1;
						state_d   = ST_MUL_LO;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_MUL_LO: begin
				ctrl.mul_lo = 1'b1;
				state_d     = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				ctrl.mul_hi = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				ctrl.check = 1'b1;
				state_d    = stat.early ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				state_d     = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`QPV_ASSERT_NOW(a_div_cnt_bound, clk, arst_n, state_q == ST_DIV, cnt_q < DIV_CNT_W'(DIV_STEPS))
	`QPV_ASSERT_NEXT(a_start_mul, clk, arst_n, in_fire && !silent && upd, state_q == ST_MUL_LO)
	`QPV_ASSERT_NOW(a_ctrl_onehot, clk, arst_n, 1'b1, $onehot0({ctrl.load, ctrl.mul_lo, ctrl.mul_hi, ctrl.check, ctrl.div_step, ctrl.finish, out_load}))
	`QPV_ASSERT_NEXT(a_finish_write, clk, arst_n, ctrl.finish, state_q == ST_WRITE)

endmodule

/* hw/rtl/quadrature_position_velocity.sv */
// Top level: x4 quadrature decoder with step count, angle and velocity.
//
//  channel  dir  word carried
//  -------  ---  ----------------------------------------------------------
//  sample   in   phase[1:0], timestamp[31:0], acknowledge
//  result   out  step_count, angle_tenths, velocity_tenths, direction, error_flag
//  wr_*     in   register write: wr_en, wr_index[1:0], wr_data[31:0]
//
// A word that only primes or sits in the error latch leaves the sequencer idle;
// one with no velocity update passes through the write state; one with an update
// runs a two-step multiply and the 33 steps of the shared restoring divider,
// skipped when the speed comes out zero or saturated. sample.ready is high only
// while the sequencer is idle; a result waits in the output register, and the
// sequencer holds in its write state while it is full and result.ready is low.
// Reset (arst_n, async) clears decoder and sequencer state; config to defaults.
module quadrature_position_velocity import qpv_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	qpv_in_if.sink      sample,
	qpv_out_if.source   result,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam int CW = COUNT_WIDTH;

	// configuration
	logic [31:0] tick_rate_q, min_interval_q, max_interval_q;
	logic        reverse_q;

	// decoder state
	logic          primed_q, err_q;
	logic [1:0]    last_phase_q;
	logic [CW-1:0] pos_q, shown_q, ref_q;
	logic [TS_W-1:0] last_time_q;
	dir_t          dir_q;

	// output register
	logic                 out_valid_q;
	logic signed [31:0]   out_step_q;
	logic signed [33:0]   out_angle_q;
	logic signed [31:0]   out_vel_q;
	logic [1:0]           out_dir_q;
	logic                 out_err_q;

	logic          in_ready, in_fire, out_load, out_free;
	logic          silent, upd;
	dir_t          dir_c;
	logic [1:0]    gray_old, gray_new, gdiff;
	logic [TS_W-1:0] gap;
	logic [CW-1:0] pos_next;
	logic [CW:0]   cdiff, cdiff_neg, cmag;
	logic [CW+2:0] mag3;
	logic [ANGLE_W-1:0] pos_wide;
	logic [VEL_W-1:0]   speed;
	arith_ctrl_t   ctrl;
	arith_stat_t   stat;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q    <= TICK_RATE_RST;
			min_interval_q <= MIN_INTERVAL_RST;
			max_interval_q <= MAX_INTERVAL_RST;
			reverse_q      <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TICK_RATE:    tick_rate_q    <= wr_data;
				REG_MIN_INTERVAL: min_interval_q <= wr_data;
				REG_MAX_INTERVAL: max_interval_q <= wr_data;
				REG_REVERSE:      reverse_q      <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Gray phase to binary position, then modulo-4 difference
	assign gray_old = last_phase_q ^ {1'b0, last_phase_q[1]};
	assign gray_new = sample.phase ^ {1'b0, sample.phase[1]};
	assign gdiff    = gray_new - gray_old;

	always_comb begin
		case (gdiff)
			2'd0:    dir_c = DIR_IDLE;
			2'd2:    dir_c = DIR_ERR;
			default: dir_c = ((gdiff == 2'd1) != reverse_q) ? DIR_FWD : DIR_BWD;
		endcase
	end

	always_comb begin
		case (dir_c)
			DIR_FWD: pos_next = pos_q + 1'b1;
			DIR_BWD: pos_next = pos_q - 1'b1;
			default: pos_next = pos_q;
		endcase
	end

	assign gap    = sample.timestamp - last_time_q;
	assign upd    = ((gap >= min_interval_q) && (dir_c != DIR_IDLE)) || (gap > max_interval_q);
	assign silent = !primed_q || err_q;

	// count moved since the last velocity update: signed, one bit wider
	assign cdiff     = {shown_q[CW-1], shown_q} - {ref_q[CW-1], ref_q};
	assign cdiff_neg = '0 - cdiff;
	assign cmag      = cdiff[CW] ? cdiff_neg : cdiff;
	assign mag3      = {1'b0, cmag, 1'b0} + {2'b00, cmag};

	assign in_fire  = sample.valid && in_ready;
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			err_q        <= 1'b0;
			last_phase_q <= '0;
			pos_q        <= '0;
			shown_q      <= '0;
			ref_q        <= '0;
			last_time_q  <= '0;
			dir_q        <= DIR_IDLE;
		end else if (in_fire) begin
			if (!primed_q) begin
				last_phase_q <= sample.phase;
				primed_q     <= 1'b1;
			end else if (err_q) begin
				// acknowledge restarts counting; shown count is kept
				if (sample.acknowledge) begin
					err_q        <= 1'b0;
					pos_q        <= '0;
					last_phase_q <= sample.phase;
				end
			end else begin
				last_phase_q <= sample.phase;
				if (upd) begin
					ref_q       <= shown_q;
					last_time_q <= sample.timestamp;
				end
				pos_q   <= pos_next;
				shown_q <= pos_next;
				err_q   <= (dir_c == DIR_ERR);
				dir_q   <= dir_c;
			end
		end
	end

	qpv_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.upd      (upd),
		.silent   (silent),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (in_ready),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	qpv_arith #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.mag_in    (mag3),
		.neg_in    (cdiff[CW]),
		.tick_rate (tick_rate_q),
		.gap       (gap),
		.stat      (stat),
		.speed     (speed)
	);

	// step count sign-extended or truncated to the angle width, times three
	assign pos_wide = ANGLE_W'($signed(pos_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_step_q  <= 32'($signed(pos_q));
			out_angle_q <= $signed({pos_wide[ANGLE_W-2:0], 1'b0} + pos_wide);
			out_vel_q   <= $signed(speed);
			out_dir_q   <= dir_q;
			out_err_q   <= (dir_q == DIR_ERR);
		end
	end

	assign sample.ready           = in_ready;
	assign result.valid           = out_valid_q;
	assign result.step_count      = out_step_q;
	assign result.angle_tenths    = out_angle_q;
	assign result.velocity_tenths = out_vel_q;
	assign result.direction       = out_dir_q;
	assign result.error_flag      = out_err_q;

endmodule

/* bench/quadrature_position_velocity_tb.sv */
// Self-checking bench for the quadrature position and velocity block: own predictor, random polls.
module quadrature_position_velocity_tb;
	import qpv_pkg::*;

	// Watchdog: cycles with no word moving on either channel.
	// The worst legitimate gap is the long receiver hold-off plus one
	// velocity update and the settling pause after a drain.
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE = 60;	// covers a no-result word still in the sequencer
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 250;	// results seen before the long hold-off

	// idling modes
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	typedef struct {
		logic [1:0]  phase;
		logic [31:0] timestamp;
		logic        acknowledge;
	} encoder_poll_t;

	typedef struct {
		logic signed [31:0] steps;
		logic signed [33:0] angle;
		logic signed [31:0] speed;
		dir_t               dir;
		logic               err;
	} shaft_word_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;

	qpv_in_if  sample_ch ();
	qpv_out_if result_ch ();

	quadrature_position_velocity dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Shadow registers and encoder state, kept in step with accepted words
	// ---------------------------------------------------------------------
	logic [31:0] cfg_tick, cfg_min, cfg_max;
	logic        cfg_rev;

	logic        enc_primed, enc_latched;
	logic [1:0]  enc_last;
	logic [31:0] enc_count;	// live step count
	logic [31:0] enc_shown;	// count shown with the previous result
	logic [31:0] enc_anchor;	// count at the last velocity update
	logic [31:0] enc_anchor_ts;
	logic [31:0] enc_speed;

	shaft_word_t   pending_results[$];	// predictions awaiting the block
	encoder_poll_t poll_queue[$];	// words not yet offered

	int unsigned words_pushed, words_taken, results_seen, mismatches;
	int unsigned speed_updates, error_latches;
	int unsigned idle_mode;

	// Gray phase to position within the cycle 00,01,11,10
	function automatic logic [1:0] bin_of(logic [1:0] g);
		return {g[1], g[1] ^ g[0]};
	endfunction

	function automatic logic [1:0] gray_of(logic [1:0] b);
		return {b[1], b[1] ^ b[0]};
	endfunction

	// Angular speed from the count moved since the last update, exact, truncated
	// toward zero and clipped to 32 bits signed.
	function automatic logic [31:0] angular_speed(logic [31:0] gap);
		logic signed [63:0] delta;
		logic [63:0]        mag;
		logic [95:0]        scaled, quo, bound;
		logic               neg;
		delta = {{32{enc_shown[31]}}, enc_shown} - {{32{enc_anchor[31]}}, enc_anchor};
		neg = delta[63];
		mag = neg ? -delta : delta;
		bound = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
		if (mag == 64'd0 || cfg_tick == 32'd0)
			return 32'd0;
		scaled = 96'(mag) * 96'd3 * 96'(cfg_tick);
		quo = (gap == 32'd0) ? bound : scaled / 96'(gap);
		if (quo > bound)
			quo = bound;
		return neg ? -quo[31:0] : quo[31:0];
	endfunction

	task automatic reset_tracker();
		cfg_tick = TICK_RATE_RST;
		cfg_min = MIN_INTERVAL_RST;
		cfg_max = MAX_INTERVAL_RST;
		cfg_rev = 1'b0;
		enc_primed = 1'b0;
		enc_latched = 1'b0;
		enc_last = 2'd0;
		enc_count = '0;
		enc_shown = '0;
		enc_anchor = '0;
		enc_anchor_ts = '0;
		enc_speed = '0;
	endtask

	// Advance the tracked encoder by one accepted poll; queue a result if one is due.
	task automatic track_sample(input logic [1:0] ph, input logic [31:0] ts, input logic ack);
		logic [1:0]  move;
		logic [31:0] gap;
		dir_t        dir;
		shaft_word_t w;
		if (!enc_primed) begin
			// first poll only primes the last phase
			enc_last = ph;
			enc_primed = 1'b1;
		end else if (enc_latched) begin
			// silent until acknowledged; ack restarts the count from zero
			if (ack) begin
				enc_latched = 1'b0;
				enc_count = '0;
				enc_last = ph;
			end
		end else begin
			move = bin_of(ph) - bin_of(enc_last);
			case (move)
				2'd0: dir = DIR_IDLE;
				2'd2: dir = DIR_ERR;
				2'd1: dir = cfg_rev ? DIR_BWD : DIR_FWD;
				default: dir = cfg_rev ? DIR_FWD : DIR_BWD;
			endcase
			enc_last = ph;

			gap = ts - enc_anchor_ts;
			if ((gap >= cfg_min && dir != DIR_IDLE) || gap > cfg_max) begin
				enc_speed = angular_speed(gap);
				enc_anchor = enc_shown;
				enc_anchor_ts = ts;
				speed_updates++;
			end

			case (dir)
				DIR_FWD: enc_count = enc_count + 32'd1;
				DIR_BWD: enc_count = enc_count - 32'd1;
				DIR_ERR: begin
					enc_latched = 1'b1;
					error_latches++;
				end
				default: ;
			endcase
			enc_shown = enc_count;

			w.steps = enc_count;
			w.angle = {{2{enc_count[31]}}, enc_count} * 34'd3;
			w.speed = enc_speed;
			w.dir = dir;
			w.err = (dir == DIR_ERR);
			pending_results.push_back(w);
		end
	endtask

	// ---------------------------------------------------------------------
	// Sender: offers queued polls, predicts on acceptance
	// ---------------------------------------------------------------------
	encoder_poll_t next_poll;

	function automatic logic sender_pause();
		int unsigned r;
		r = $urandom_range(99, 0);
		return (idle_mode == IDLE_SEND && r < 48) || (idle_mode == IDLE_BOTH && r < 12);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.phase <= 2'd0;
			sample_ch.timestamp <= 32'd0;
			sample_ch.acknowledge <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				track_sample(sample_ch.phase, sample_ch.timestamp, sample_ch.acknowledge);
				words_taken++;
			end
			// slot is free when nothing is offered or the offer was just taken
			if (!sample_ch.valid || sample_ch.ready) begin
				if (poll_queue.size() != 0 && !sender_pause()) begin
					next_poll = poll_queue.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.phase <= next_poll.phase;
					sample_ch.timestamp <= next_poll.timestamp;
					sample_ch.acknowledge <= next_poll.acknowledge;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random stalls, one long hold-off, word-by-word comparison
	// ---------------------------------------------------------------------
	int unsigned hold_left;
	logic        held_once;
	shaft_word_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left <= 0;
			held_once <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] result word with nothing expected: steps %0d dir %0d",
							$time, result_ch.step_count, result_ch.direction);
				end else begin
					want = pending_results.pop_front();
					if (result_ch.step_count !== want.steps ||
						result_ch.angle_tenths !== want.angle ||
						result_ch.velocity_tenths !== want.speed ||
						result_ch.direction !== want.dir ||
						result_ch.error_flag !== want.err) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] result %0d mismatch: exp steps %0d angle %0d vel %0d dir %0d err %0d",
								$time, results_seen, want.steps, want.angle, want.speed,
								want.dir, want.err);
							$display("    got steps %0d angle %0d vel %0d dir %0d err %0d",
								result_ch.step_count, result_ch.angle_tenths,
								result_ch.velocity_tenths, result_ch.direction,
								result_ch.error_flag);
						end
					end
				end
			end

			// long hold-off once, so the output register fills and input stalls
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (!held_once && results_seen >= HOLD_AFTER) begin
				held_once <= 1'b1;
				hold_left <= HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				case (idle_mode)
					IDLE_RECV: result_ch.ready <= ($urandom_range(99, 0) >= 48);
					IDLE_BOTH: result_ch.ready <= ($urandom_range(99, 0) >= 12);
					default:   result_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog
	// ---------------------------------------------------------------------
	int unsigned quiet;

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d predictions outstanding",
				QUIET_LIMIT, pending_results.size());
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	logic [1:0]  gen_phase;	// where the generator believes the shaft sits
	logic [31:0] gen_ts;
	logic        gen_fwd;

	task automatic push_poll(input logic [1:0] ph, input logic [31:0] ts, input logic ack);
		encoder_poll_t p;
		p.phase = ph;
		p.timestamp = ts;
		p.acknowledge = ack;
		poll_queue.push_back(p);
		words_pushed++;
		gen_phase = ph;
		gen_ts = ts;
	endtask

	// registers only change while the block is idle
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		case (idx)
			REG_TICK_RATE:    cfg_tick = v;
			REG_MIN_INTERVAL: cfg_min = v;
			REG_MAX_INTERVAL: cfg_max = v;
			default:          cfg_rev = v[0];
		endcase
	endtask

	task automatic apply_config(input logic [31:0] tick, input logic [31:0] lo,
		input logic [31:0] hi, input logic rev);
		write_reg(REG_TICK_RATE, tick);
		write_reg(REG_MIN_INTERVAL, lo);
		write_reg(REG_MAX_INTERVAL, hi);
		write_reg(REG_REVERSE, {31'd0, rev});
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// wait for every poll to be taken and every result to arrive, then let a
	// silent word finish in the sequencer
	task automatic drain();
		while (words_taken != words_pushed || pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic advance_ts(input int unsigned span);
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 3)
			gen_ts = gen_ts;	// zero gap
		else if (r < 5)
			gen_ts = $urandom;	// anywhere, wrap and backwards included
		else
			gen_ts = gen_ts + $urandom_range(span, 0);
	endtask

	// a few silent polls while latched, then an acknowledge from a fresh phase
	task automatic recover(input int unsigned span);
		repeat ($urandom_range(2, 0)) begin
			advance_ts(span);
			push_poll(2'($urandom), gen_ts, 1'b0);
		end
		advance_ts(span);
		push_poll(2'($urandom), gen_ts, 1'b1);
	endtask

	// Mostly clean Gray walks with runs in one direction, some idle polls,
	// occasional illegal jumps and random noise.
	task automatic random_polls(input int unsigned n, input int unsigned span);
		int unsigned r;
		logic [1:0]  ph;
		repeat (n) begin
			r = $urandom_range(99, 0);
			advance_ts(span);
			if ($urandom_range(9, 0) == 0)
				gen_fwd = ~gen_fwd;
			if (r < 70) begin
				ph = gray_of(bin_of(gen_phase) + (gen_fwd ? 2'd1 : 2'd3));
				push_poll(ph, gen_ts, ($urandom_range(99, 0) < 3));
			end else if (r < 82) begin
				push_poll(gen_phase, gen_ts, 1'b0);
			end else if (r < 86) begin
				push_poll(gen_phase ^ 2'b11, gen_ts, 1'b0);
				recover(span);
			end else begin
				ph = 2'($urandom);
				r = ((ph ^ gen_phase) == 2'b11);
				push_poll(ph, gen_ts, 1'($urandom));
				if (r != 0)
					recover(span);
			end
		end
	endtask

	task automatic run_phase(input logic [31:0] tick, input logic [31:0] lo,
		input logic [31:0] hi, input logic rev, input int unsigned mode,
		input int unsigned span, input int unsigned n);
		apply_config(tick, lo, hi, rev);
		idle_mode = mode;
		random_polls(n, span);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_TICK_RATE;
		wr_data = 32'd0;
		idle_mode = IDLE_NONE;
		words_pushed = 0;
		words_taken = 0;
		results_seen = 0;
		mismatches = 0;
		speed_updates = 0;
		error_latches = 0;
		gen_phase = 2'd0;
		gen_ts = 32'd0;
		gen_fwd = 1'b1;
		reset_tracker();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, part one: full tick rate, velocity on any movement.
		// Priming, zero gap with movement, both saturations,
		// timestamp wrap, stray acknowledge, an illegal jump and its recovery.
		apply_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
		push_poll(2'b00, 32'd0, 1'b0);
		push_poll(2'b01, 32'd0, 1'b0);
		push_poll(2'b11, 32'd0, 1'b0);
		push_poll(2'b11, 32'd5, 1'b0);
		push_poll(2'b01, 32'd5, 1'b0);
		push_poll(2'b00, 32'd6, 1'b0);
		push_poll(2'b10, 32'hFFFF_FFFF, 1'b0);
		push_poll(2'b10, 32'd5, 1'b1);
		push_poll(2'b01, 32'd9, 1'b0);
		push_poll(2'b11, 32'd10, 1'b0);
		push_poll(2'b00, 32'd11, 1'b0);
		push_poll(2'b11, 32'd12, 1'b1);
		push_poll(2'b10, 32'd13, 1'b0);
		drain();

		// Directed, part two: reversed sense, slowest tick, widest intervals,
		// a full-range gap and the other pair of illegal jumps.
		apply_config(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_poll(2'b11, 32'd20, 1'b0);
		push_poll(2'b01, 32'd20 + 32'hFFFF_FFFF, 1'b0);
		push_poll(2'b01, 32'd40, 1'b0);
		push_poll(2'b00, 32'd41, 1'b0);
		push_poll(2'b11, 32'd42, 1'b0);
		push_poll(2'b10, 32'd43, 1'b0);
		push_poll(2'b00, 32'd44, 1'b1);
		push_poll(2'b01, 32'd45, 1'b0);
		push_poll(2'b10, 32'd46, 1'b0);
		push_poll(2'b10, 32'd47, 1'b1);
		drain();

		// Random phases: register settings from narrow to extreme, each under
		// one of the four idling patterns in turn.
		run_phase(32'd1000, 32'd50, 32'd200, 1'b0, IDLE_NONE, 60, 110);
		run_phase(32'd90000000, 32'd100, 32'd300, 1'b1, IDLE_SEND, 80, 110);
		run_phase(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, IDLE_RECV, 20, 110);
		run_phase(32'd1, 32'hFFFF_FFFF, 32'd0, 1'b1, IDLE_BOTH, 1000, 110);
		run_phase(32'd7, 32'd10, 32'd40, 1'b0, IDLE_NONE, 30, 110);
		run_phase(TICK_RATE_RST, MIN_INTERVAL_RST, MAX_INTERVAL_RST, 1'b0, IDLE_SEND,
			30000000, 110);
		run_phase($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(500, 0),
			$urandom_range(2000, 0), 1'($urandom), IDLE_RECV, 400, 110);
		run_phase(32'd12345678, 32'd5, 32'hFFFF_FFFF, 1'b1, IDLE_BOTH, 15, 110);

		$display("covered %0d polls, %0d result words, %0d velocity updates, %0d error latches",
			words_taken, results_seen, speed_updates, error_latches);
		$display("register settings: 10, long receiver hold-off: %0s",
			held_once ? "done" : "not reached");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d predictions left", mismatches, pending_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* quadrature_position_velocity.f */
+incdir+hw/rtl
hw/rtl/qpv_pkg.sv
hw/rtl/qpv_in_if.sv
hw/rtl/qpv_out_if.sv
hw/rtl/qpv_arith.sv
hw/rtl/qpv_seq.sv
hw/rtl/quadrature_position_velocity.sv
bench/quadrature_position_velocity_tb.sv
